// File: hdl/plm_pkg.sv
// Shared constants, types and stage payloads for the peak-hold level meter.
package plm_pkg;

    localparam int PEAK_FRAC_BITS = 8;
    localparam int MAX_SECTIONS   = 64;

    localparam int LEVEL_W  = 8;
    localparam int PEAK_W   = 16;
    localparam int SEC_W    = 7;
    localparam int SCALED_W = 15;
    localparam int LPROD_W  = 14;
    localparam int PPROD_W  = 22;
    localparam int LQ_W     = 8;
    localparam int PQ_W     = 16;
    localparam int MUL_W    = 45;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // floor(x / 100) for x < 2**22 is (x * RECIP_MUL) >> RECIP_SHIFT, or one below it
    localparam int          DIVISOR     = 100;
    localparam int          RECIP_SHIFT = 29;
    localparam logic [22:0] RECIP_MUL   = 23'd5368709;

    localparam logic [PEAK_W-1:0]   PEAK_RESET       = PEAK_W'(100 << PEAK_FRAC_BITS);
    localparam logic [PEAK_W-1:0]   FALL_RATE_RESET  = 16'd256;
    localparam logic [SEC_W-1:0]    SECTIONS_RESET   = 7'd16;
    localparam logic [SCALED_W-1:0] SHOWN_PEAK_RESET = SCALED_W'(16 << PEAK_FRAC_BITS);

    typedef enum logic [1:0] {
        PEAK_OFF    = 2'd0,
        PEAK_HOLD   = 2'd1,
        PEAK_SMOOTH = 2'd2
    } peak_mode_t;

    typedef enum logic [1:0] {
        REG_PEAK_MODE     = 2'd0,
        REG_FALL_RATE     = 2'd1,
        REG_SECTION_COUNT = 2'd2
    } reg_index_t;

    typedef struct packed {
        peak_mode_t        mode;
        logic [PEAK_W-1:0] rate;
        logic [SEC_W-1:0]  sections;   // already limited to MAX_SECTIONS
    } plm_cfg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [PEAK_W-1:0]  peak;
    } plm_s1_t;

    typedef struct packed {
        logic [LPROD_W-1:0] lprod;
        logic [PPROD_W-1:0] pprod;
        logic [PEAK_W-1:0]  peak;
    } plm_s2_t;

    typedef struct packed {
        logic [LPROD_W-1:0] lprod;
        logic [PPROD_W-1:0] pprod;
        logic [LQ_W-1:0]    lq;
        logic [PQ_W-1:0]    pq;
        logic [PEAK_W-1:0]  peak;
    } plm_s3_t;

endpackage

// File: hdl/plm_regs.sv
// APB configuration registers: peak mode, fall rate and section count.
module plm_regs import plm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output plm_cfg_t              cfg
);

    peak_mode_t        peak_mode_reg;
    logic [PEAK_W-1:0] fall_rate_reg;
    logic [SEC_W-1:0]  section_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_mode_reg     <= PEAK_OFF;
            fall_rate_reg     <= FALL_RATE_RESET;
            section_count_reg <= SECTIONS_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_PEAK_MODE:     peak_mode_reg     <= peak_mode_t'(pwdata[1:0]);
                REG_FALL_RATE:     fall_rate_reg     <= pwdata[PEAK_W-1:0];
                REG_SECTION_COUNT: section_count_reg <= pwdata[SEC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_PEAK_MODE:     prdata = APB_DATA_W'(peak_mode_reg);
            REG_FALL_RATE:     prdata = APB_DATA_W'(fall_rate_reg);
            REG_SECTION_COUNT: prdata = APB_DATA_W'(section_count_reg);
            default:           prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    assign cfg.mode     = peak_mode_reg;
    assign cfg.rate     = fall_rate_reg;
    assign cfg.sections = (section_count_reg > SEC_W'(MAX_SECTIONS)) ?
                          SEC_W'(MAX_SECTIONS) : section_count_reg;

endmodule

// File: hdl/plm_peak.sv
// Input stage: peak tracker state and its per-sample update.
module plm_peak import plm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  plm_cfg_t           cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [LEVEL_W-1:0] in_level,
    output logic               out_valid,
    input  logic               out_ready,
    output plm_s1_t            out_data
);

    logic              valid_reg;
    plm_s1_t           data_reg;
    logic [PEAK_W-1:0] peak_value_reg;
    logic [PEAK_W-1:0] peak_next;
    logic [PEAK_W-1:0] target;
    logic [PEAK_W-1:0] diff_up;
    logic [PEAK_W-1:0] diff_dn;
    logic [PEAK_W-1:0] fall_down;
    logic              accept;

    assign target  = PEAK_W'(in_level) << PEAK_FRAC_BITS;
    assign diff_up = target - peak_value_reg;
    assign diff_dn = peak_value_reg - target;
    // drop by the rate, never below the sample
    assign fall_down = (diff_dn <= cfg.rate) ? target : peak_value_reg - cfg.rate;

    always_comb begin
        case (cfg.mode)
            PEAK_OFF:  peak_next = '0;
            PEAK_HOLD: peak_next = (target >= peak_value_reg) ? target : fall_down;
            default: begin
                // smooth: climb by the rate without overshoot, else fall
                if (target > peak_value_reg) begin
                    peak_next = (diff_up <= cfg.rate) ? target : peak_value_reg + cfg.rate;
                end else begin
                    peak_next = fall_down;
                end
            end
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            peak_value_reg <= PEAK_RESET;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (accept) begin
                peak_value_reg <= peak_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            data_reg.level <= in_level;
            data_reg.peak  <= peak_next;
        end
    end

endmodule

// File: hdl/plm_scale.sv
// Scaling stages: multiply by the section count, then estimate the quotient by 100.
module plm_scale import plm_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  plm_cfg_t cfg,
    input  logic     in_valid,
    output logic     in_ready,
    input  plm_s1_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output plm_s3_t  out_data
);

    logic             s2_valid_reg;
    plm_s2_t          s2_reg;
    logic             s3_valid_reg;
    plm_s3_t          s3_reg;
    logic             s2_ready;
    logic             s3_ready;
    logic [MUL_W-1:0] lmul;
    logic [MUL_W-1:0] pmul;

    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign in_ready = s2_ready;

    assign lmul = MUL_W'(s2_reg.lprod) * MUL_W'(RECIP_MUL);
    assign pmul = MUL_W'(s2_reg.pprod) * MUL_W'(RECIP_MUL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            if (s2_ready) begin
                s2_valid_reg <= in_valid;
            end
            if (s3_ready) begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && s2_ready) begin
            s2_reg.lprod <= LPROD_W'(in_data.level) * LPROD_W'(cfg.sections);
            s2_reg.pprod <= PPROD_W'(in_data.peak) * PPROD_W'(cfg.sections);
            s2_reg.peak  <= in_data.peak;
        end
        if (s2_valid_reg && s3_ready) begin
            s3_reg.lprod <= s2_reg.lprod;
            s3_reg.pprod <= s2_reg.pprod;
            s3_reg.lq    <= LQ_W'(lmul >> RECIP_SHIFT);
            s3_reg.pq    <= PQ_W'(pmul >> RECIP_SHIFT);
            s3_reg.peak  <= s2_reg.peak;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = s3_reg;

endmodule

// File: hdl/plm_redraw.sv
// Output stage: quotient correction, clamping, redraw detection and result register.
module plm_redraw import plm_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  plm_cfg_t           cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  plm_s3_t            in_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [SEC_W-1:0]   m_level_sections,
    output logic [SEC_W-1:0]   m_peak_sections,
    output logic               m_peak_visible,
    output logic [PEAK_W-1:0]  m_peak_level,
    output logic               m_redraw
);

    logic                m_valid_reg;
    logic [SEC_W-1:0]    level_sections_reg;
    logic [SCALED_W-1:0] peak_scaled_reg;
    logic [PEAK_W-1:0]   peak_level_reg;
    logic                redraw_reg;
    logic [SEC_W-1:0]    shown_level_reg;
    logic [SCALED_W-1:0] shown_peak_reg;

    logic [LPROD_W-1:0]  lrem;
    logic [PPROD_W-1:0]  prem;
    logic [LQ_W-1:0]     lq_fixed;
    logic [PQ_W-1:0]     pq_fixed;
    logic [SCALED_W-1:0] full_scaled;
    logic [SEC_W-1:0]    lsec;
    logic [SCALED_W-1:0] psc;
    logic                redraw;
    logic                load;

    // the estimate may sit one below the true quotient
    assign lrem     = in_data.lprod - LPROD_W'(in_data.lq) * LPROD_W'(DIVISOR);
    assign prem     = in_data.pprod - PPROD_W'(in_data.pq) * PPROD_W'(DIVISOR);
    assign lq_fixed = (lrem >= LPROD_W'(DIVISOR)) ? in_data.lq + 1'b1 : in_data.lq;
    assign pq_fixed = (prem >= PPROD_W'(DIVISOR)) ? in_data.pq + 1'b1 : in_data.pq;

    assign full_scaled = SCALED_W'(cfg.sections) << PEAK_FRAC_BITS;
    assign lsec = (lq_fixed > LQ_W'(cfg.sections)) ? cfg.sections : SEC_W'(lq_fixed);
    assign psc  = (pq_fixed > PQ_W'(full_scaled)) ? full_scaled : SCALED_W'(pq_fixed);

    assign redraw = (lsec != shown_level_reg) || (psc != shown_peak_reg);

    assign in_ready = !m_valid_reg || m_ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg     <= 1'b0;
            shown_level_reg <= '0;
            shown_peak_reg  <= SHOWN_PEAK_RESET;
        end else begin
            if (in_ready) begin
                m_valid_reg <= in_valid;
            end
            if (load && redraw) begin
                shown_level_reg <= lsec;
                shown_peak_reg  <= psc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            level_sections_reg <= lsec;
            peak_scaled_reg    <= psc;
            peak_level_reg     <= in_data.peak;
            redraw_reg         <= redraw;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_level_sections = level_sections_reg;
    assign m_peak_sections  = peak_scaled_reg[SCALED_W-1:PEAK_FRAC_BITS];
    assign m_peak_visible   = (peak_scaled_reg != '0);
    assign m_peak_level     = peak_level_reg;
    assign m_redraw         = redraw_reg;

endmodule

// File: hdl/peak_hold_level_meter_core.sv
// Peak-hold level meter core: one sample in, one scaled result out per transaction.
// Throughput: one transaction per cycle while m_ready is high; each stage advances when the next one frees up.
// Stages: peak update, section multiply, reciprocal multiply, correction and result register.
// Reset: synchronous, active low; empties the pipeline, peak at full scale,
// registers to mode off, fall rate 1.0 and 16 sections.
module peak_hold_level_meter_core import plm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [LEVEL_W-1:0]    s_level,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SEC_W-1:0]      m_level_sections,
    output logic [SEC_W-1:0]      m_peak_sections,
    output logic                  m_peak_visible,
    output logic [PEAK_W-1:0]     m_peak_level,
    output logic                  m_redraw,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    plm_cfg_t cfg;
    logic     s1_valid;
    logic     s1_ready;
    plm_s1_t  s1_data;
    logic     s3_valid;
    logic     s3_ready;
    plm_s3_t  s3_data;

    plm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    plm_peak u_peak (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_level  (s_level),
        .out_valid (s1_valid),
        .out_ready (s1_ready),
        .out_data  (s1_data)
    );

    plm_scale u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_data   (s1_data),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_data  (s3_data)
    );

    plm_redraw u_redraw (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .in_valid         (s3_valid),
        .in_ready         (s3_ready),
        .in_data          (s3_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_level_sections (m_level_sections),
        .m_peak_sections  (m_peak_sections),
        .m_peak_visible   (m_peak_visible),
        .m_peak_level     (m_peak_level),
        .m_redraw         (m_redraw)
    );

endmodule

// File: hdl/plm_checker.sv
// Port-level checks on the level meter core, bound to the top level.
module plm_checker import plm_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [SEC_W-1:0]      m_level_sections,
    input logic [SEC_W-1:0]      m_peak_sections,
    input logic                  m_peak_visible,
    input logic [PEAK_W-1:0]     m_peak_level,
    input logic                  m_redraw
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_level_sections)
            && $stable(m_peak_sections) && $stable(m_peak_level) && $stable(m_redraw))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid straight after reset");

    a_marker_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_peak_sections != '0) |-> m_peak_visible)
        else $error("peak marker index set but marker hidden");

    a_zero_peak_hidden: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_peak_level == '0) |-> !m_peak_visible && (m_peak_sections == '0))
        else $error("zero peak shown");

    a_section_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_level_sections <= SEC_W'(MAX_SECTIONS))
            && (m_peak_sections <= SEC_W'(MAX_SECTIONS)))
        else $error("section count out of range");

endmodule

bind peak_hold_level_meter_core plm_checker u_plm_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_level_sections (m_level_sections),
    .m_peak_sections  (m_peak_sections),
    .m_peak_visible   (m_peak_visible),
    .m_peak_level     (m_peak_level),
    .m_redraw         (m_redraw)
);
